### src/hse_pkg.sv
// Shared types, constants and saturation helper for the Hermite slope estimator.
`timescale 1ns / 1ps
package hse_pkg;

  // Field widths fixed by the stream format.
  localparam int DATA_W  = 32;
  localparam int PNUM_W  = 16;
  // Width used for intermediate sums before saturation.
  localparam int WIDE_W  = 68;

  // Defaults for the top-level parameters.
  localparam int MAX_POINTS_DEF = 65536;
  localparam int FRAC_BITS_DEF  = 16;

  // Result selector codes for the output register.
  localparam logic [2:0] EM_SHORT_A = 3'd0;
  localparam logic [2:0] EM_SHORT_B = 3'd1;
  localparam logic [2:0] EM_FIRST   = 3'd2;
  localparam logic [2:0] EM_MID     = 3'd3;
  localparam logic [2:0] EM_LAST    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       commit_k0;
    logic       commit_k1;
    logic       div_start;
    logic       div_weight;
    logic       mul_start;
    logic       save_dn;
    logic       save_w;
    logic       calc_mid;
    logic       calc_ends;
    logic       emit;
    logic [2:0] emit_sel;
  } hse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic k_zero;
    logic k_one;
    logic k_two;
    logic fin;
    logic unit_done;
    logic unit_busy;
    logic out_free;
  } hse_sts_t;

  // Saturates a wide signed value to 32 bits; the top bit of the result is the overflow flag.
  function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] a);
    logic ovf;
    logic [DATA_W-1:0] val;
    ovf = !((&a[WIDE_W-1:DATA_W-1]) || !(|a[WIDE_W-1:DATA_W-1]));
    if (ovf) begin
      val = a[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      val = a[DATA_W-1:0];
    end
    return {ovf, val};
  endfunction

endpackage

### src/hse_arith.sv
// Shared iterative unit: fixed-point divide with saturation and shift-add multiply.
`timescale 1ns / 1ps
module hse_arith #(
  parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          div_start,
  input  logic                          mul_start,
  input  logic signed [32:0]            num,
  input  logic signed [33:0]            den,
  input  logic signed [31:0]            mul_a,
  input  logic signed [32:0]            mul_b,
  output logic                          busy,
  output logic                          done,
  output logic signed [31:0]            q,
  output logic                          q_err,
  output logic signed [65-FRAC_BITS:0]  t
);
  import hse_pkg::*;

  localparam int NMW = 33 + FRAC_BITS;
  localparam int DMW = 34;
  localparam int RW  = DMW + 1;
  localparam int CW  = $clog2(NMW + 1);
  localparam int TW  = 66 - FRAC_BITS;
  localparam int PW  = 65;

  logic            is_div;
  logic            neg;
  logic [CW-1:0]   cnt;
  logic [NMW-1:0]  quo;
  logic [RW-1:0]   rem;
  logic [DMW-1:0]  dmag;
  logic [31:0]     ma;
  logic [PW-1:0]   mb;
  logic [PW-1:0]   macc;

  logic [32:0]     nmag;
  logic [DMW-1:0]  den_mag;
  logic [RW-1:0]   rem_sh;
  logic            qbit;
  logic [RW-1:0]   rem_new;
  logic signed [NMW:0] qs;
  logic [DATA_W:0] qsat;
  logic [PW-1:0]   msh;

  // Operand magnitudes and one restoring-division step.
  always_comb begin
    nmag    = num[32] ? 33'(-num) : 33'(num);
    den_mag = den[33] ? DMW'(-den) : DMW'(den);
    rem_sh  = {rem[RW-2:0], quo[NMW-1]};
    qbit    = (rem_sh >= {1'b0, dmag});
    rem_new = qbit ? (rem_sh - {1'b0, dmag}) : rem_sh;
    qs      = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    qsat    = sat32(WIDE_W'(qs));
    msh     = macc >> FRAC_BITS;
  end

  // Iteration control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (div_start) begin
        is_div <= 1'b1;
        neg    <= num[32] ^ den[33];
        if (den == '0) begin
          q     <= (num == '0) ? 32'sd0 :
                   (num[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}});
          q_err <= 1'b1;
          done  <= 1'b1;
        end else begin
          quo  <= {nmag, {FRAC_BITS{1'b0}}};
          rem  <= '0;
          dmag <= den_mag;
          cnt  <= CW'(NMW);
          busy <= 1'b1;
        end
      end else if (mul_start) begin
        is_div <= 1'b0;
        neg    <= mul_a[31] ^ mul_b[32];
        ma     <= mul_a[31] ? 32'(-mul_a) : 32'(mul_a);
        mb     <= PW'(mul_b[32] ? 33'(-mul_b) : 33'(mul_b));
        macc   <= '0;
        cnt    <= CW'(32);
        busy   <= 1'b1;
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          if (is_div) begin
            rem <= rem_new;
            quo <= {quo[NMW-2:0], qbit};
          end else begin
            if (ma[0]) begin
              macc <= macc + mb;
            end
            mb <= mb << 1;
            ma <= ma >> 1;
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (is_div) begin
            q     <= qsat[DATA_W-1:0];
            q_err <= qsat[DATA_W];
          end else begin
            t <= neg ? -$signed({1'b0, msh[TW-2:0]}) : $signed({1'b0, msh[TW-2:0]});
          end
        end
      end
    end
  end

endmodule

### src/hse_dp.sv
// Datapath: point history, arithmetic unit, slope combination and output register.
`timescale 1ns / 1ps
module hse_dp #(
  parameter int FRAC_BITS  = hse_pkg::FRAC_BITS_DEF,
  parameter int MAX_POINTS = hse_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_v,
  input  logic                          in_fin,
  input  hse_pkg::hse_cmd_t             cmd,
  output hse_pkg::hse_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [31:0]            out_slope,
  output logic [hse_pkg::PNUM_W-1:0]    out_pnum,
  output logic                          out_end,
  output logic                          out_err
);
  import hse_pkg::*;

  localparam int TW = 66 - FRAC_BITS;

  // Current item.
  logic signed [31:0]  cur_x;
  logic signed [31:0]  cur_v;
  logic                cur_fin;
  logic [PNUM_W-1:0]   cur_k;

  // Sequence history.
  logic signed [31:0]  older_x;
  logic signed [31:0]  newer_x;
  logic signed [31:0]  newer_value;
  logic signed [31:0]  prev_sec;
  logic [PNUM_W-1:0]   points_seen;
  logic                sticky;

  // Per-point intermediates.
  logic signed [31:0]  d_next;
  logic signed [31:0]  w;
  logic signed [31:0]  mid;
  logic signed [31:0]  first_s;
  logic signed [31:0]  last_s;
  logic                step_err;
  logic                run_err;

  logic signed [32:0]  sec_num;
  logic signed [33:0]  sec_den;
  logic signed [32:0]  hp;
  logic signed [32:0]  hn;
  logic signed [33:0]  hsum;
  logic signed [32:0]  dif;
  logic signed [32:0]  a_num;
  logic signed [33:0]  a_den;
  logic                a_busy;
  logic                a_done;
  logic signed [31:0]  a_q;
  logic                a_qerr;
  logic signed [TW-1:0] a_t;
  logic [DATA_W:0]     mid_sat;
  logic [DATA_W:0]     first_sat;
  logic [DATA_W:0]     last_sat;
  logic                ends_err;
  logic                fin_eff;

  // Operand selection for the shared unit.
  always_comb begin
    sec_num = 33'(cur_v) - 33'(newer_value);
    hn      = 33'(cur_x) - 33'(newer_x);
    hp      = 33'(newer_x) - 33'(older_x);
    sec_den = 34'(hn);
    hsum    = 34'(hp) + 34'(hn);
    dif     = 33'(prev_sec) - 33'(d_next);
    a_num   = cmd.div_weight ? hp : sec_num;
    a_den   = cmd.div_weight ? hsum : sec_den;
    fin_eff = in_fin || ({1'b0, points_seen} >= 17'(MAX_POINTS - 1));
  end

  hse_arith #(
    .FRAC_BITS(FRAC_BITS)
  ) u_arith (
    .clk      (clk),
    .rst      (rst),
    .div_start(cmd.div_start),
    .mul_start(cmd.mul_start),
    .num      (a_num),
    .den      (a_den),
    .mul_a    (w),
    .mul_b    (dif),
    .busy     (a_busy),
    .done     (a_done),
    .q        (a_q),
    .q_err    (a_qerr),
    .t        (a_t)
  );

  // Slope combination and end extrapolation.
  always_comb begin
    mid_sat   = sat32(WIDE_W'(d_next) + WIDE_W'(a_t));
    first_sat = sat32(WIDE_W'(prev_sec) + WIDE_W'(prev_sec) - WIDE_W'(mid));
    last_sat  = sat32(WIDE_W'(d_next) + WIDE_W'(d_next) - WIDE_W'(mid));
    ends_err  = step_err || (sts.k_two && first_sat[DATA_W]) ||
                (cur_fin && last_sat[DATA_W]);
  end

  // Status back to the controller.
  always_comb begin
    sts.k_zero    = (cur_k == '0);
    sts.k_one     = (cur_k == PNUM_W'(1));
    sts.k_two     = (cur_k == PNUM_W'(2));
    sts.fin       = cur_fin;
    sts.unit_done = a_done;
    sts.unit_busy = a_busy;
    sts.out_free  = !out_valid || out_ready;
  end

  // Item capture and intermediates.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_x   <= in_x;
      cur_v   <= in_v;
      cur_fin <= fin_eff;
      cur_k   <= points_seen;
    end
    if (cmd.save_dn) begin
      d_next   <= a_q;
      step_err <= a_qerr;
    end
    if (cmd.save_w) begin
      w        <= a_q;
      step_err <= step_err || a_qerr;
    end
    if (cmd.calc_mid) begin
      mid      <= mid_sat[DATA_W-1:0];
      step_err <= step_err || mid_sat[DATA_W];
    end
    if (cmd.calc_ends) begin
      first_s <= first_sat[DATA_W-1:0];
      last_s  <= last_sat[DATA_W-1:0];
      run_err <= sticky || ends_err;
    end
  end

  // Sequence history updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
      sticky      <= 1'b0;
    end else if (cmd.commit_k0) begin
      newer_x     <= cur_x;
      newer_value <= cur_v;
      points_seen <= cur_fin ? '0 : PNUM_W'(1);
      if (cur_fin) begin
        sticky <= 1'b0;
      end
    end else if (cmd.commit_k1) begin
      prev_sec    <= a_q;
      older_x     <= newer_x;
      newer_x     <= cur_x;
      newer_value <= cur_v;
      points_seen <= cur_fin ? '0 : PNUM_W'(2);
      sticky      <= cur_fin ? 1'b0 : (sticky || a_qerr);
    end else if (cmd.calc_ends) begin
      prev_sec    <= d_next;
      older_x     <= newer_x;
      newer_x     <= cur_x;
      newer_value <= cur_v;
      points_seen <= cur_fin ? '0 : cur_k + 1'b1;
      sticky      <= cur_fin ? 1'b0 : (sticky || ends_err);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        EM_SHORT_A: begin
          out_slope <= '0;
          out_pnum  <= '0;
          out_end   <= sts.k_zero;
          out_err   <= 1'b1;
        end
        EM_SHORT_B: begin
          out_slope <= '0;
          out_pnum  <= PNUM_W'(1);
          out_end   <= 1'b1;
          out_err   <= 1'b1;
        end
        EM_FIRST: begin
          out_slope <= first_s;
          out_pnum  <= '0;
          out_end   <= 1'b0;
          out_err   <= run_err;
        end
        EM_MID: begin
          out_slope <= mid;
          out_pnum  <= cur_k - 1'b1;
          out_end   <= 1'b0;
          out_err   <= run_err;
        end
        EM_LAST: begin
          out_slope <= last_s;
          out_pnum  <= cur_k;
          out_end   <= 1'b1;
          out_err   <= run_err;
        end
        default: begin
          out_slope <= '0;
          out_pnum  <= '0;
          out_end   <= 1'b0;
          out_err   <= 1'b1;
        end
      endcase
    end
  end

endmodule

### src/hse_ctrl.sv
// Controller state machine that sequences the datapath for each point.
`timescale 1ns / 1ps
module hse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hse_pkg::hse_sts_t sts,
  output hse_pkg::hse_cmd_t cmd
);
  import hse_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_WAIT_SEC = 4'd2;
  localparam logic [3:0] S_EM_SA    = 4'd3;
  localparam logic [3:0] S_EM_SB    = 4'd4;
  localparam logic [3:0] S_WAIT_DN  = 4'd5;
  localparam logic [3:0] S_DIV_W    = 4'd6;
  localparam logic [3:0] S_WAIT_W   = 4'd7;
  localparam logic [3:0] S_MUL      = 4'd8;
  localparam logic [3:0] S_WAIT_MUL = 4'd9;
  localparam logic [3:0] S_CALC     = 4'd10;
  localparam logic [3:0] S_EM_FIRST = 4'd11;
  localparam logic [3:0] S_EM_MID   = 4'd12;
  localparam logic [3:0] S_EM_LAST  = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.k_zero) begin
          cmd.commit_k0 = 1'b1;
          state_next    = sts.fin ? S_EM_SA : S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = sts.k_one ? S_WAIT_SEC : S_WAIT_DN;
        end
      end
      S_WAIT_SEC: begin
        if (sts.unit_done) begin
          cmd.commit_k1 = 1'b1;
          state_next    = sts.fin ? S_EM_SA : S_IDLE;
        end
      end
      S_EM_SA: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SHORT_A;
          state_next   = sts.k_zero ? S_IDLE : S_EM_SB;
        end
      end
      S_EM_SB: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SHORT_B;
          state_next   = S_IDLE;
        end
      end
      S_WAIT_DN: begin
        if (sts.unit_done) begin
          cmd.save_dn = 1'b1;
          state_next  = S_DIV_W;
        end
      end
      S_DIV_W: begin
        cmd.div_start  = 1'b1;
        cmd.div_weight = 1'b1;
        state_next     = S_WAIT_W;
      end
      S_WAIT_W: begin
        if (sts.unit_done) begin
          cmd.save_w = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_WAIT_MUL;
      end
      S_WAIT_MUL: begin
        if (sts.unit_done) begin
          cmd.calc_mid = 1'b1;
          state_next   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc_ends = 1'b1;
        state_next    = sts.k_two ? S_EM_FIRST : S_EM_MID;
      end
      S_EM_FIRST: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_FIRST;
          state_next   = S_EM_MID;
        end
      end
      S_EM_MID: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_MID;
          state_next   = sts.fin ? S_EM_LAST : S_IDLE;
        end
      end
      S_EM_LAST: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_LAST;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/hermite_slope_estimator.sv
// Top level of the three-point Hermite slope estimator.
//
//  Channel  Direction  Signals                          Contents
//  s_*      in         s_tvalid s_tready s_tdata s_tlast grid point, last-point mark
//  m_*      out        m_tvalid m_tready m_tdata m_tlast slope, index, end mark,
//                      m_tuser                           error flag
//
// One point is taken at a time. Point 0 is stored; point 1 also needs one secant
// division on the shared iterative unit. A later point needs two divisions and one
// 32-step multiply on the shared iterative unit, then up to three result transfers
// through one output register.
// Reset clears the sequence position and the error flag; no clearing pass is needed.
// A stalled output holds the controller until each result transfer completes.
`timescale 1ns / 1ps
module hermite_slope_estimator #(
  parameter int MAX_POINTS    = hse_pkg::MAX_POINTS_DEF,
  parameter int FRACTION_BITS = hse_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // grid_x [31:0], grid_value [63:32]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // slope [31:0], point_number [47:32]
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // math_error [0]
);
  import hse_pkg::*;

  hse_cmd_t           cmd;
  hse_sts_t           sts;
  logic signed [31:0] slope;
  logic [PNUM_W-1:0]  point_number;
  logic               math_error;

  hse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  hse_dp #(
    .FRAC_BITS (FRACTION_BITS),
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_x     (s_tdata[31:0]),
    .in_v     (s_tdata[63:32]),
    .in_fin   (s_tlast),
    .cmd      (cmd),
    .sts      (sts),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_slope(slope),
    .out_pnum (point_number),
    .out_end  (m_tlast),
    .out_err  (math_error)
  );

  assign m_tdata = {point_number, slope};
  assign m_tuser = math_error;

`ifndef ASSERT_OFF
  // No point is taken while the arithmetic unit is still working.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !sts.unit_busy)
    else $error("point taken while arithmetic unit busy");

  // The unit is never restarted in the middle of an operation.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start || cmd.mul_start) |-> !sts.unit_busy)
    else $error("arithmetic unit restarted while busy");

  // A result is loaded only into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending transfer");
`endif

endmodule
